// ----- sv/afc_pkg.sv -----
// Package for the AABB frustum cull test: sizes, action codes, shared types
// and the coordinate reduction function. No dependencies.
package afc_pkg;

  // Number of frustum planes held in the table.
  localparam int PLANE_COUNT    = 6;
  // Significant bits of a box coordinate; 32 or more keeps the full field.
  localparam int COORD_WIDTH    = 32;
  localparam int COORD_EFF      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int COORD_SHIFT    = 32 - COORD_EFF;

  localparam int AXES           = 3;
  localparam int COEF_PER_PLANE = 4;
  localparam int COEF_W         = 32;
  localparam int PROD_W         = 2 * COEF_W;
  localparam int D_ALIGN_SHIFT  = 16;

  // Action codes of an input transaction.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // Coefficient codes within a plane.
  localparam logic [1:0] COEF_A = 2'd0;
  localparam logic [1:0] COEF_B = 2'd1;
  localparam logic [1:0] COEF_C = 2'd2;
  localparam logic [1:0] COEF_D = 2'd3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // One plane row: a, b, c, d packed by coefficient code.
  typedef logic [COEF_PER_PLANE-1:0][COEF_W-1:0] plane_row_t;
  // One box corner: x, y, z.
  typedef logic [AXES-1:0][COEF_W-1:0] corner_t;

  // Stage enables handed from the pipeline control to every plane lane.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } afc_lane_ctrl_t;

  // Reduce a coordinate field to COORD_EFF bits and sign-extend it again.
  function automatic coef_t coord_of(input coef_t v);
    coef_t t;
    t = v <<< COORD_SHIFT;
    return t >>> COORD_SHIFT;
  endfunction

endpackage

// ----- sv/afc_if.sv -----
// Valid/ready channel interfaces for the AABB frustum cull test.
// Depends on afc_pkg for the coefficient type.
interface afc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [2:0]         plane_index;
  logic [1:0]         coef_index;
  afc_pkg::coef_t     coef_value;
  afc_pkg::coef_t     min_x;
  afc_pkg::coef_t     min_y;
  afc_pkg::coef_t     min_z;
  afc_pkg::coef_t     max_x;
  afc_pkg::coef_t     max_y;
  afc_pkg::coef_t     max_z;

  modport source (
    output valid, action, plane_index, coef_index, coef_value,
    output min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, action, plane_index, coef_index, coef_value,
    input  min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

interface afc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// ----- sv/afc_plane_lane.sv -----
// One plane lane of the cull pipeline: corner selection, three products,
// a two-level adder and the sign test. Depends on afc_pkg.
module afc_plane_lane (
  input  logic                    clk,
  input  afc_pkg::afc_lane_ctrl_t ctrl,
  input  afc_pkg::plane_row_t     row,
  input  afc_pkg::corner_t        lo_corner,
  input  afc_pkg::corner_t        hi_corner,
  output logic                    neg
);

  afc_pkg::coef_t k1_r [afc_pkg::AXES];
  afc_pkg::coef_t q1_r [afc_pkg::AXES];
  afc_pkg::coef_t d1_r;
  afc_pkg::prod_t prod2_r [afc_pkg::AXES];
  afc_pkg::prod_t d2_r;
  logic signed [afc_pkg::PROD_W:0]   sum3a_r;
  logic signed [afc_pkg::PROD_W:0]   sum3b_r;
  logic signed [afc_pkg::PROD_W+1:0] total;
  logic                              neg4_r;

  // Stage 1: pick the corner on each axis from the sign of the coefficient.
  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      for (int a = 0; a < afc_pkg::AXES; a++) begin
        k1_r[a] <= $signed(row[a]);
        q1_r[a] <= ($signed(row[a]) > 0) ? $signed(hi_corner[a]) : $signed(lo_corner[a]);
      end
      d1_r <= $signed(row[afc_pkg::COEF_D]);
    end
  end

  // Stage 2: one 32x32 product per axis, d aligned to Q32.32.
  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      for (int a = 0; a < afc_pkg::AXES; a++) begin
        prod2_r[a] <= $signed({{afc_pkg::COEF_W{k1_r[a][afc_pkg::COEF_W-1]}}, k1_r[a]}) *
                      $signed({{afc_pkg::COEF_W{q1_r[a][afc_pkg::COEF_W-1]}}, q1_r[a]});
      end
      d2_r <= $signed({{(afc_pkg::COEF_W - afc_pkg::D_ALIGN_SHIFT){d1_r[afc_pkg::COEF_W-1]}},
                       d1_r, {afc_pkg::D_ALIGN_SHIFT{1'b0}}});
    end
  end

  // Stage 3: two pairwise sums, one bit wider than the products.
  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      sum3a_r <= $signed({prod2_r[0][afc_pkg::PROD_W-1], prod2_r[0]}) +
                 $signed({prod2_r[1][afc_pkg::PROD_W-1], prod2_r[1]});
      sum3b_r <= $signed({prod2_r[2][afc_pkg::PROD_W-1], prod2_r[2]}) +
                 $signed({d2_r[afc_pkg::PROD_W-1], d2_r});
    end
  end

  // Stage 4: the exact plane distance and its sign.
  assign total = $signed({sum3a_r[afc_pkg::PROD_W], sum3a_r}) +
                 $signed({sum3b_r[afc_pkg::PROD_W], sum3b_r});

  always_ff @(posedge clk) begin
    if (ctrl.s4_en) begin
      neg4_r <= total[afc_pkg::PROD_W+1];
    end
  end

  assign neg = neg4_r;

endmodule

// ----- sv/aabb_frustum_cull_test.sv -----
// AABB frustum cull test: an accepted test transaction goes through the four-stage
// plane pipeline and the output register after it to its result on out_ch; one
// transaction per cycle sustained while out_ch keeps ready high.
// Load transactions update the plane table and produce no result.
// Synchronous active-low reset clears all valid bits; the plane table is not
// cleared and reads as undefined until each entry has been loaded.
module aabb_frustum_cull_test (
  input logic       clk,
  input logic       rst_n,
  afc_in_if.sink    in_ch,
  afc_out_if.source out_ch
);

  // Plane table: one row of a, b, c, d per plane. Every lane reads its own
  // row directly, so the table is plain flops written at one address.
  afc_pkg::plane_row_t table_r [afc_pkg::PLANE_COUNT];

  // Pipeline valid bits, one per stage, plus the output register.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic out_valid_r, out_valid_nxt;
  logic visible_r, visible_nxt;

  // A stage may load when it is empty or its contents move on this cycle.
  logic adv1, adv2, adv3, adv4, adv_out;

  logic in_acc;
  logic test_acc;
  logic load_acc;

  afc_pkg::afc_lane_ctrl_t lane_ctrl;
  afc_pkg::corner_t        lo_corner;
  afc_pkg::corner_t        hi_corner;
  logic [afc_pkg::PLANE_COUNT-1:0] plane_neg;

  assign adv_out = !out_valid_r || out_ch.ready;
  assign adv4    = !v4_r || adv_out;
  assign adv3    = !v3_r || adv4;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;

  // The input side only waits when every stage and the output are full.
  assign in_ch.ready = adv1;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign test_acc    = in_acc && (in_ch.action == afc_pkg::ACT_TEST);
  assign load_acc    = in_acc && (in_ch.action == afc_pkg::ACT_LOAD);

  // Loads to a plane beyond the table are dropped.
  always_ff @(posedge clk) begin
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
      if (load_acc && (32'(in_ch.plane_index) == p)) begin
        table_r[p][in_ch.coef_index] <= in_ch.coef_value;
      end
    end
  end

  // Corners are reduced to the coordinate width before selection.
  assign lo_corner[0] = afc_pkg::coord_of(in_ch.min_x);
  assign lo_corner[1] = afc_pkg::coord_of(in_ch.min_y);
  assign lo_corner[2] = afc_pkg::coord_of(in_ch.min_z);
  assign hi_corner[0] = afc_pkg::coord_of(in_ch.max_x);
  assign hi_corner[1] = afc_pkg::coord_of(in_ch.max_y);
  assign hi_corner[2] = afc_pkg::coord_of(in_ch.max_z);

  // Stage 1 captures coefficients together with the corners, so a load that
  // follows a test cannot change the planes that test sees.
  assign lane_ctrl.s1_en = adv1;
  assign lane_ctrl.s2_en = adv2;
  assign lane_ctrl.s3_en = adv3;
  assign lane_ctrl.s4_en = adv4;

  for (genvar p = 0; p < afc_pkg::PLANE_COUNT; p++) begin : g_lane
    afc_plane_lane u_lane (
      .clk       (clk),
      .ctrl      (lane_ctrl),
      .row       (table_r[p]),
      .lo_corner (lo_corner),
      .hi_corner (hi_corner),
      .neg       (plane_neg[p])
    );
  end

  always_comb begin
    v1_nxt = adv1 ? test_acc : v1_r;
    v2_nxt = adv2 ? v1_r     : v2_r;
    v3_nxt = adv3 ? v2_r     : v3_r;
    v4_nxt = adv4 ? v3_r     : v4_r;
    out_valid_nxt = adv_out ? v4_r : out_valid_r;
    // A zero distance is visible; any negative plane culls the box.
    visible_nxt = adv_out ? !(|plane_neg) : visible_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    visible_r <= visible_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.visible = visible_r;

`ifndef NO_ASSERTIONS
  // Back-pressure reaches the input only when the whole pipeline is full.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r && !out_ch.ready))
    else $error("input blocked while a pipeline stage is empty");

  // A load transaction never enters the result pipeline.
  a_load_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !v1_r)
    else $error("load transaction occupied a pipeline slot");

  // A held stage keeps its transaction while the next stage is blocked.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv3) |=> v2_r)
    else $error("stalled pipeline stage lost its transaction");

  // A new result only appears when the last stage held a transaction.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v4_r))
    else $error("result appeared without a transaction in the last stage");
`endif

endmodule

// ----- dv/tb_aabb_frustum_cull_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for aabb_frustum_cull_test: directed table, then random frustums.
// Depends on afc_pkg, the afc_in_if / afc_out_if interfaces and the block itself.
module tb_aabb_frustum_cull_test;

  // Frustum plane slots as software lays them out.
  localparam logic [2:0] PLANE_NEAR   = 3'd0;
  localparam logic [2:0] PLANE_FAR    = 3'd1;
  localparam logic [2:0] PLANE_LEFT   = 3'd2;
  localparam logic [2:0] PLANE_RIGHT  = 3'd3;
  localparam logic [2:0] PLANE_TOP    = 3'd4;
  localparam logic [2:0] PLANE_BOTTOM = 3'd5;

  // Outcome of a directed row when it is obvious without computing it.
  localparam int KNOWN_NONE    = -1;
  localparam int KNOWN_CULLED  = 0;
  localparam int KNOWN_VISIBLE = 1;

  localparam afc_pkg::coef_t Q_MIN = 32'sh8000_0000;
  localparam afc_pkg::coef_t Q_MAX = 32'sh7FFF_FFFF;
  localparam afc_pkg::coef_t Q_ONE = 32'sh0001_0000;

  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 8;

  // One input transaction plus, for directed rows, an outcome typed in by hand.
  typedef struct {
    logic           action;
    logic [2:0]     plane_index;
    logic [1:0]     coef_index;
    afc_pkg::coef_t coef_value;
    afc_pkg::coef_t min_x, min_y, min_z;
    afc_pkg::coef_t max_x, max_y, max_z;
    int             known;
  } cull_item_t;

  logic clk = 1'b0;
  logic rst_n;

  afc_in_if  in_ch ();
  afc_out_if out_ch ();

  aabb_frustum_cull_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the plane table, kept in step with every accepted load.
  afc_pkg::coef_t plane_shadow [afc_pkg::PLANE_COUNT][afc_pkg::COEF_PER_PLANE];
  // Visibility bits still owed by the block, oldest first.
  logic  visible_expected [$];
  int    mismatches = 0;
  // When set, the matching side runs without idle cycles for a while.
  bit    src_flat  = 1'b0;
  bit    sink_flat = 1'b0;

  // Reduce a coordinate to COORD_EFF significant bits and extend its sign again.
  function automatic afc_pkg::coef_t narrow_coord(afc_pkg::coef_t v);
    afc_pkg::coef_t r;
    r = v;
    for (int b = afc_pkg::COORD_EFF; b < afc_pkg::COEF_W; b++) r[b] = v[afc_pkg::COORD_EFF-1];
    return r;
  endfunction

  // Exact plane-side test of a box. Each plane picks the corner that maximizes
  // its value, so the box is culled only when even that corner is behind it.
  function automatic logic predict_visible(cull_item_t it);
    afc_pkg::coef_t         lo_c [afc_pkg::AXES];
    afc_pkg::coef_t         hi_c [afc_pkg::AXES];
    afc_pkg::coef_t         k;
    afc_pkg::coef_t         q;
    logic signed [63:0]     prod;
    logic signed [47:0]     d_term;
    logic signed [67:0]     acc;
    logic                   vis;
    lo_c[0] = narrow_coord(it.min_x);
    lo_c[1] = narrow_coord(it.min_y);
    lo_c[2] = narrow_coord(it.min_z);
    hi_c[0] = narrow_coord(it.max_x);
    hi_c[1] = narrow_coord(it.max_y);
    hi_c[2] = narrow_coord(it.max_z);
    vis = 1'b1;
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
      acc = '0;
      for (int a = 0; a < afc_pkg::AXES; a++) begin
        k = plane_shadow[p][a];
        // Only a strictly positive coefficient takes the max corner.
        q = (k > 0) ? hi_c[a] : lo_c[a];
        prod = k * q;
        acc = acc + prod;
      end
      // d is Q16.16 while the products are Q32.32.
      d_term = {plane_shadow[p][afc_pkg::COEF_D], 16'h0000};
      acc = acc + d_term;
      // Zero sits on the plane and still counts as visible.
      if (acc < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  // Account for an accepted transaction: loads update the shadow table (out-of-range
  // planes are dropped, as in the block), tests queue their visibility bit.
  function automatic void absorb_item(cull_item_t it);
    logic vis;
    if (it.action == afc_pkg::ACT_LOAD) begin
      if (it.plane_index < afc_pkg::PLANE_COUNT)
        plane_shadow[it.plane_index][it.coef_index] = it.coef_value;
    end else begin
      vis = predict_visible(it);
      if (it.known != KNOWN_NONE) vis = (it.known == KNOWN_VISIBLE);
      visible_expected.push_back(vis);
    end
  endfunction

  function automatic afc_pkg::coef_t pick_wide();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return -1;
      default: return afc_pkg::coef_t'($urandom());
    endcase
  endfunction

  // Small values around the origin: a few hundredths in Q16.16.
  function automatic afc_pkg::coef_t pick_small();
    return afc_pkg::coef_t'($urandom_range(0, 8191)) - 4096;
  endfunction

  // A load transaction; the box fields carry junk since the block must ignore them.
  function automatic cull_item_t load_row(logic [2:0] p, logic [1:0] c, afc_pkg::coef_t v);
    cull_item_t it;
    it.action      = afc_pkg::ACT_LOAD;
    it.plane_index = p;
    it.coef_index  = c;
    it.coef_value  = v;
    it.min_x = afc_pkg::coef_t'($urandom());
    it.min_y = afc_pkg::coef_t'($urandom());
    it.min_z = afc_pkg::coef_t'($urandom());
    it.max_x = afc_pkg::coef_t'($urandom());
    it.max_y = afc_pkg::coef_t'($urandom());
    it.max_z = afc_pkg::coef_t'($urandom());
    it.known = KNOWN_NONE;
    return it;
  endfunction

  // A test transaction; the load fields carry junk.
  function automatic cull_item_t test_row(afc_pkg::coef_t mnx, afc_pkg::coef_t mny,
                                          afc_pkg::coef_t mnz, afc_pkg::coef_t mxx,
                                          afc_pkg::coef_t mxy, afc_pkg::coef_t mxz,
                                          int known);
    cull_item_t it;
    it.action      = afc_pkg::ACT_TEST;
    it.plane_index = 3'($urandom());
    it.coef_index  = 2'($urandom());
    it.coef_value  = afc_pkg::coef_t'($urandom());
    it.min_x = mnx;
    it.min_y = mny;
    it.min_z = mnz;
    it.max_x = mxx;
    it.max_y = mxy;
    it.max_z = mxz;
    it.known = known;
    return it;
  endfunction

  // Random box: mostly small and well ordered, sometimes full range, sometimes swapped.
  function automatic cull_item_t random_box(bit wide);
    afc_pkg::coef_t lo [afc_pkg::AXES];
    afc_pkg::coef_t hi [afc_pkg::AXES];
    afc_pkg::coef_t t;
    for (int a = 0; a < afc_pkg::AXES; a++) begin
      lo[a] = wide ? pick_wide() : pick_small();
      hi[a] = wide ? pick_wide() : pick_small();
      if (lo[a] > hi[a] && $urandom_range(0, 6) != 0) begin
        t     = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    return test_row(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], KNOWN_NONE);
  endfunction

  // Present one transaction and hold it until accepted. Handshake inputs are
  // sampled at the falling edge, where nothing is changing, and the transaction
  // counts as taken at the rising edge that follows.
  task automatic drive_item(cull_item_t it);
    int gap;
    bit took;
    gap = src_flat ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= it.action;
    in_ch.plane_index <= it.plane_index;
    in_ch.coef_index  <= it.coef_index;
    in_ch.coef_value  <= it.coef_value;
    in_ch.min_x       <= it.min_x;
    in_ch.min_y       <= it.min_y;
    in_ch.min_z       <= it.min_z;
    in_ch.max_x       <= it.max_x;
    in_ch.max_y       <= it.max_y;
    in_ch.max_z       <= it.max_z;
    do begin
      @(negedge clk);
      took = (in_ch.ready === 1'b1);
      @(posedge clk);
    end while (!took);
    absorb_item(it);
  endtask

  // Load a whole frustum. Roughly half the coefficients are drawn benign (small normal
  // entries, large positive offset) so that a fair share of small boxes survive all six.
  task automatic drive_frustum();
    afc_pkg::coef_t v;
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
      for (int c = 0; c < afc_pkg::COEF_PER_PLANE; c++) begin
        if ($urandom_range(0, 1) == 0)
          v = (c == afc_pkg::COEF_D)
                ? afc_pkg::coef_t'($urandom_range(32'h0010_0000, 32'h4000_0000))
                : pick_small();
        else
          v = pick_wide();
        drive_item(load_row(3'(p), 2'(c), v));
      end
    end
  endtask

  cull_item_t directed_rows [$];

  initial begin : stimulus
    int sent;
    int run_len;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= afc_pkg::ACT_LOAD;
    in_ch.plane_index <= '0;
    in_ch.coef_index  <= afc_pkg::COEF_A;
    in_ch.coef_value  <= '0;
    in_ch.min_x       <= '0;
    in_ch.min_y       <= '0;
    in_ch.min_z       <= '0;
    in_ch.max_x       <= '0;
    in_ch.max_y       <= '0;
    in_ch.max_z       <= '0;
    rst_n             <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is undefined after reset, so every entry is written before
    // the first box is tested.
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++)
      for (int c = 0; c < afc_pkg::COEF_PER_PLANE; c++)
        drive_item(load_row(3'(p), 2'(c), '0));

    // Directed table. With every plane at zero, every box lies on all planes.
    directed_rows.push_back(test_row('0, '0, '0, '0, '0, '0, KNOWN_VISIBLE));
    directed_rows.push_back(test_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, KNOWN_VISIBLE));
    // Loads aimed past the last plane must leave the table alone.
    directed_rows.push_back(load_row(3'(afc_pkg::PLANE_COUNT), afc_pkg::COEF_A, Q_MIN));
    directed_rows.push_back(load_row(3'(afc_pkg::PLANE_COUNT + 1), afc_pkg::COEF_D, -1));
    directed_rows.push_back(test_row('0, '0, '0, '0, '0, '0, KNOWN_VISIBLE));
    // Most negative a: the min corner is chosen, swapped corners included.
    directed_rows.push_back(load_row(PLANE_NEAR, afc_pkg::COEF_A, Q_MIN));
    directed_rows.push_back(test_row(Q_MAX, '0, '0, Q_MIN, '0, '0, KNOWN_CULLED));
    directed_rows.push_back(test_row(Q_MIN, '0, '0, Q_MAX, '0, '0, KNOWN_VISIBLE));
    // Most positive a: the max corner is chosen.
    directed_rows.push_back(load_row(PLANE_NEAR, afc_pkg::COEF_A, Q_MAX));
    directed_rows.push_back(test_row(Q_MAX, '0, '0, Q_MIN, '0, '0, KNOWN_CULLED));
    directed_rows.push_back(load_row(PLANE_NEAR, afc_pkg::COEF_A, '0));
    // Offset of minus one LSB culls everything until c balances it exactly.
    directed_rows.push_back(load_row(PLANE_RIGHT, afc_pkg::COEF_D, -1));
    directed_rows.push_back(test_row('0, '0, '0, '0, '0, '0, KNOWN_CULLED));
    directed_rows.push_back(load_row(PLANE_RIGHT, afc_pkg::COEF_C, Q_ONE));
    directed_rows.push_back(test_row('0, '0, Q_MIN, '0, '0, 32'sd1, KNOWN_VISIBLE));
    directed_rows.push_back(test_row('0, '0, '0, '0, '0, '0, KNOWN_CULLED));
    // Extreme offsets and mixed coefficients, left to the predictor.
    directed_rows.push_back(load_row(PLANE_FAR, afc_pkg::COEF_B, Q_MAX));
    directed_rows.push_back(load_row(PLANE_FAR, afc_pkg::COEF_D, Q_MAX));
    directed_rows.push_back(load_row(PLANE_TOP, afc_pkg::COEF_D, Q_MIN));
    directed_rows.push_back(load_row(PLANE_TOP, afc_pkg::COEF_A, Q_MAX));
    directed_rows.push_back(load_row(PLANE_LEFT, afc_pkg::COEF_C, -1));
    directed_rows.push_back(load_row(PLANE_BOTTOM, afc_pkg::COEF_B, Q_MIN));
    directed_rows.push_back(test_row('0, Q_MIN, -1, Q_MAX, '0, Q_ONE, KNOWN_NONE));
    directed_rows.push_back(test_row(-1, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MAX, KNOWN_NONE));
    foreach (directed_rows[i]) drive_item(directed_rows[i]);

    // Random part: a fresh frustum, then a run of boxes with a little load noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_flat  = ($urandom_range(0, 3) == 0);
      sink_flat = ($urandom_range(0, 3) == 0);
      drive_frustum();
      sent += afc_pkg::PLANE_COUNT * afc_pkg::COEF_PER_PLANE;
      run_len = $urandom_range(15, 40);
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(0, 9))
          0:       drive_item(load_row(3'($urandom()), 2'($urandom()), pick_wide()));
          1, 2:    drive_item(random_box(1'b1));
          default: drive_item(random_box(1'b0));
        endcase
      end
      sent += run_len;
    end
    in_ch.valid <= 1'b0;

    while (visible_expected.size() != 0) @(posedge clk);
    // Keep the clock running so that any stray result shows up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: before each result, hold ready low for a random stall unless
  // sink_flat is set, then hold it high until one transaction has gone through.
  initial begin : result_sink
    int stall;
    bit took;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = sink_flat ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = (out_ch.valid === 1'b1);
        @(posedge clk);
      end while (!took);
    end
  end

  // Checker. Signals are stable at the falling edge, and a transaction seen
  // there with valid and ready high completes at the next rising edge.
  always @(negedge clk) begin
    logic want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (visible_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual visible=%b",
                 $time, out_ch.visible);
        mismatches++;
      end else begin
        want = visible_expected.pop_front();
        if (out_ch.visible !== want) begin
          $display("%0t: visible mismatch, expected %b, actual %b",
                   $time, want, out_ch.visible);
          mismatches++;
        end
      end
    end
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
